// ===== sv/fcre_pkg.sv =====
// Shared types and codes for the forward-chaining rule engine.
`timescale 1ns / 1ps
`default_nettype none

package fcre_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_SCAN
  } state_e;

  // Request modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result kinds
  localparam logic KIND_STEP   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Run status codes
  localparam logic [1:0] STAT_REACHED = 2'd0;
  localparam logic [1:0] STAT_KNOWN   = 2'd1;
  localparam logic [1:0] STAT_MISSED  = 2'd2;

  // Fixed field widths
  localparam int unsigned MaskW = 64;
  localparam int unsigned SymW  = 6;
  localparam int unsigned SlotW = 5;
  localparam int unsigned CntW  = 6;

endpackage

`default_nettype wire

// ===== sv/forward_chaining_rule_engine_core.sv =====
// Forward-chaining rule engine: rule memory, fact register and scan sequencer.
// A rule load gives no result. A query runs passes: each pass checks the goal,
// then scans the rules in use in slot order until one fires or the last one is
// checked; the single rule memory read port checks one rule per cycle. Each
// result is strobed for one cycle; the status result follows the last step at
// the earliest in the cycle after it. The core takes one request at a time.
// Reset clears the rule count and the sequencer; rule memory contents are
// undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module forward_chaining_rule_engine_core #(
  parameter int unsigned MAX_RULES    = 32,
  parameter int unsigned SYMBOL_COUNT = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fcre_pkg::CntW-1:0]         cfg_wdata_i,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              mode_i,
  input  wire logic [fcre_pkg::SlotW-1:0]        rule_slot_i,
  input  wire logic [fcre_pkg::MaskW-1:0]        condition_mask_i,
  input  wire logic [fcre_pkg::SymW-1:0]         conclusion_symbol_i,
  input  wire logic [fcre_pkg::MaskW-1:0]        initial_facts_i,
  input  wire logic [fcre_pkg::SymW-1:0]         goal_symbol_i,
  output logic                                   result_valid_o,
  output logic                                   item_kind_o,
  output logic [fcre_pkg::CntW-1:0]              fired_rule_o,
  output logic [1:0]                             status_o,
  output logic [fcre_pkg::MaskW-1:0]             final_facts_o,
  output logic                                   last_item_o
);

  localparam int unsigned IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [fcre_pkg::MaskW-1:0] AlphaMask =
    fcre_pkg::MaskW'((65'(1) << SYMBOL_COUNT) - 65'(1));
  localparam logic [fcre_pkg::CntW-1:0] MaxRules = fcre_pkg::CntW'(MAX_RULES);
  localparam logic [fcre_pkg::SymW:0]   SymLimit = (fcre_pkg::SymW + 1)'(SYMBOL_COUNT);

  fcre_pkg::state_e state_q, state_d;

  logic [fcre_pkg::CntW-1:0]  rule_count_q;
  logic [fcre_pkg::CntW-1:0]  limit;
  logic [fcre_pkg::MaskW-1:0] facts_q, facts_d;
  logic [fcre_pkg::SymW-1:0]  goal_q, goal_d;
  logic [fcre_pkg::CntW-1:0]  pass_q, pass_d;
  logic [fcre_pkg::CntW-1:0]  idx_q, idx_d;
  logic [fcre_pkg::CntW-1:0]  idx_inc;

  // Rule memory, one read port with registered data
  logic [fcre_pkg::MaskW-1:0] cond_mem  [MAX_RULES];
  logic [fcre_pkg::SymW-1:0]  concl_mem [MAX_RULES];
  logic [fcre_pkg::MaskW-1:0] rd_cond_q;
  logic [fcre_pkg::SymW-1:0]  rd_concl_q;
  logic [IdxW-1:0]            rd_addr;
  logic [IdxW-1:0]            wr_addr;
  logic [fcre_pkg::CntW-1:0]  slot_ext;
  logic                       mem_we;

  logic accept;
  logic goal_hit;
  logic concl_ok;
  logic fire;
  logic last_rule;
  logic [fcre_pkg::MaskW-1:0] fired_facts;

  logic                       emit;
  logic                       res_valid_q;
  logic                       kind_q, kind_d;
  logic [fcre_pkg::CntW-1:0]  rule_q, rule_d;
  logic [1:0]                 stat_q, stat_d;
  logic [fcre_pkg::MaskW-1:0] out_facts_q, out_facts_d;

  assign busy_o = (state_q != fcre_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;

  assign limit = (rule_count_q > MaxRules) ? MaxRules : rule_count_q;

  assign slot_ext = {1'b0, rule_slot_i};
  assign wr_addr  = slot_ext[IdxW-1:0];
  assign mem_we   = accept && (mode_i == fcre_pkg::MODE_LOAD) && (slot_ext < MaxRules);

  assign goal_hit = ({1'b0, goal_q} < SymLimit) && facts_q[goal_q];
  assign concl_ok = ({1'b0, rd_concl_q} < SymLimit);
  assign fire     = ((facts_q & rd_cond_q) == rd_cond_q) && concl_ok && !facts_q[rd_concl_q];
  assign fired_facts = facts_q | (fcre_pkg::MaskW'(1) << rd_concl_q);
  assign idx_inc   = idx_q + fcre_pkg::CntW'(1);
  assign last_rule = (idx_inc == limit);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cond_mem[wr_addr]  <= condition_mask_i & AlphaMask;
      concl_mem[wr_addr] <= conclusion_symbol_i;
    end
    rd_cond_q  <= cond_mem[rd_addr];
    rd_concl_q <= concl_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcre_pkg::ST_IDLE: begin
        if (accept && (mode_i == fcre_pkg::MODE_QUERY)) state_d = fcre_pkg::ST_PASS;
      end
      fcre_pkg::ST_PASS: begin
        if (goal_hit || (pass_q == limit)) state_d = fcre_pkg::ST_IDLE;
        else state_d = fcre_pkg::ST_SCAN;
      end
      fcre_pkg::ST_SCAN: begin
        if (fire) state_d = fcre_pkg::ST_PASS;
        else if (last_rule) state_d = fcre_pkg::ST_IDLE;
      end
      default: state_d = fcre_pkg::ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    facts_d     = facts_q;
    goal_d      = goal_q;
    pass_d      = pass_q;
    idx_d       = idx_q;
    rd_addr     = '0;
    emit        = 1'b0;
    kind_d      = kind_q;
    rule_d      = rule_q;
    stat_d      = stat_q;
    out_facts_d = out_facts_q;
    unique case (state_q)
      fcre_pkg::ST_IDLE: begin
        if (accept && (mode_i == fcre_pkg::MODE_QUERY)) begin
          facts_d = initial_facts_i & AlphaMask;
          goal_d  = goal_symbol_i;
          pass_d  = '0;
        end
      end
      fcre_pkg::ST_PASS: begin
        // Facts only grow by firing, so a hit before any pass means known
        if (goal_hit) begin
          emit        = 1'b1;
          kind_d      = fcre_pkg::KIND_STATUS;
          rule_d      = '0;
          stat_d      = (pass_q == '0) ? fcre_pkg::STAT_KNOWN : fcre_pkg::STAT_REACHED;
          out_facts_d = facts_q;
        end else if (pass_q == limit) begin
          emit        = 1'b1;
          kind_d      = fcre_pkg::KIND_STATUS;
          rule_d      = '0;
          stat_d      = fcre_pkg::STAT_MISSED;
          out_facts_d = facts_q;
        end else begin
          idx_d = '0;
        end
      end
      fcre_pkg::ST_SCAN: begin
        // Prefetch the next rule while this one is checked
        if (idx_inc < MaxRules) rd_addr = idx_inc[IdxW-1:0];
        if (fire) begin
          facts_d     = fired_facts;
          pass_d      = pass_q + fcre_pkg::CntW'(1);
          emit        = 1'b1;
          kind_d      = fcre_pkg::KIND_STEP;
          rule_d      = idx_inc;
          stat_d      = fcre_pkg::STAT_REACHED;
          out_facts_d = fired_facts;
        end else if (last_rule) begin
          // A pass that fires nothing leaves every later pass idle too
          emit        = 1'b1;
          kind_d      = fcre_pkg::KIND_STATUS;
          rule_d      = '0;
          stat_d      = fcre_pkg::STAT_MISSED;
          out_facts_d = facts_q;
        end else begin
          idx_d = idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fcre_pkg::ST_IDLE;
      rule_count_q <= '0;
      pass_q       <= '0;
      idx_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) rule_count_q <= cfg_wdata_i;
      pass_q      <= pass_d;
      idx_q       <= idx_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    facts_q     <= facts_d;
    goal_q      <= goal_d;
    kind_q      <= kind_d;
    rule_q      <= rule_d;
    stat_q      <= stat_d;
    out_facts_q <= out_facts_d;
  end

  assign result_valid_o = res_valid_q;
  assign item_kind_o    = kind_q;
  assign fired_rule_o   = rule_q;
  assign status_o       = stat_q;
  assign final_facts_o  = out_facts_q;
  assign last_item_o    = (kind_q == fcre_pkg::KIND_STATUS);

endmodule

`default_nettype wire

// ===== sv/fcre_checker.sv =====
// Port-level checks for the rule engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fcre_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start_i,
  input wire logic                      busy_o,
  input wire logic                      mode_i,
  input wire logic                      result_valid_o,
  input wire logic                      item_kind_o,
  input wire logic [fcre_pkg::CntW-1:0] fired_rule_o,
  input wire logic [1:0]                status_o,
  input wire logic                      last_item_o
);

  // A query transfer always starts a run
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i == fcre_pkg::MODE_QUERY)) |=> busy_o)
    else $error("query transfer did not start a run");

  // A rule load gives no result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i == fcre_pkg::MODE_LOAD)) |=> (!busy_o && !result_valid_o))
    else $error("rule load produced activity");

  // Results only come out of a run
  a_result_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result outside a run");

  // The status result ends the run
  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (item_kind_o == fcre_pkg::KIND_STATUS)) |->
      (last_item_o && !busy_o && (fired_rule_o == '0) &&
       (status_o != 2'd3)))
    else $error("malformed status result");

  // Path steps name a real rule and are never last
  a_step_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (item_kind_o == fcre_pkg::KIND_STEP)) |->
      ((fired_rule_o != '0) && !last_item_o && busy_o &&
       (status_o == fcre_pkg::STAT_REACHED)))
    else $error("malformed path step");

endmodule

bind forward_chaining_rule_engine_core fcre_checker u_fcre_checker (.*);

`default_nettype wire

// ===== bench/tb_forward_chaining_rule_engine_core.sv =====
// Self-checking bench for the forward-chaining rule engine core: rule loads, queries, rule count.
`timescale 1ns / 1ps

module tb_forward_chaining_rule_engine_core;

  localparam int unsigned MaskW      = fcre_pkg::MaskW;
  localparam int unsigned SymW       = fcre_pkg::SymW;
  localparam int unsigned SlotW      = fcre_pkg::SlotW;
  localparam int unsigned CntW       = fcre_pkg::CntW;
  localparam int unsigned RuleSlots  = 32;
  localparam int unsigned PoolSize   = 10;
  localparam int unsigned RandItems  = 360;
  localparam int unsigned CycleLimit = 3_000_000;

  typedef struct {
    logic             mode;
    logic [SlotW-1:0] slot;
    logic [MaskW-1:0] cond;
    logic [SymW-1:0]  concl;
    logic [MaskW-1:0] facts;
    logic [SymW-1:0]  goal;
  } request_t;

  typedef struct {
    logic             kind;
    logic [CntW-1:0]  rule;
    logic [1:0]       stat;
    logic [MaskW-1:0] facts;
    logic             last;
  } outcome_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CntW-1:0]  cfg_wdata_i = '0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic             mode_i = 1'b0;
  logic [SlotW-1:0] rule_slot_i = '0;
  logic [MaskW-1:0] condition_mask_i = '0;
  logic [SymW-1:0]  conclusion_symbol_i = '0;
  logic [MaskW-1:0] initial_facts_i = '0;
  logic [SymW-1:0]  goal_symbol_i = '0;
  logic             result_valid_o;
  logic             item_kind_o;
  logic [CntW-1:0]  fired_rule_o;
  logic [1:0]       status_o;
  logic [MaskW-1:0] final_facts_o;
  logic             last_item_o;

  // Shadow of the rule memory and rule count register
  logic [MaskW-1:0] rule_cond [RuleSlots];
  logic [SymW-1:0]  rule_concl[RuleSlots];
  logic [CntW-1:0]  rule_count_q = '0;

  request_t request_q[$];
  outcome_t expected_q[$];
  request_t cur_req;
  logic [SymW-1:0] sym_pool[PoolSize];
  int burst_left = 0;
  int idle_left = 0;
  int fail_count = 0;
  int cycle_cnt = 0;

  forward_chaining_rule_engine_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .mode_i             (mode_i),
    .rule_slot_i        (rule_slot_i),
    .condition_mask_i   (condition_mask_i),
    .conclusion_symbol_i(conclusion_symbol_i),
    .initial_facts_i    (initial_facts_i),
    .goal_symbol_i      (goal_symbol_i),
    .result_valid_o     (result_valid_o),
    .item_kind_o        (item_kind_o),
    .fired_rule_o       (fired_rule_o),
    .status_o           (status_o),
    .final_facts_o      (final_facts_o),
    .last_item_o        (last_item_o)
  );

  always #2 clk_i = ~clk_i;

  // Apply a load, or chain a query forward and queue its path steps and status
  task automatic derive_outcomes(input request_t rq);
    logic [MaskW-1:0] known;
    int lim;
    outcome_t o;
    if (rq.mode == fcre_pkg::MODE_LOAD) begin
      rule_cond[rq.slot]  = rq.cond;
      rule_concl[rq.slot] = rq.concl;
    end else begin
      known = rq.facts;
      if (known[rq.goal]) begin
        o = '{fcre_pkg::KIND_STATUS, '0, fcre_pkg::STAT_KNOWN, known, 1'b1};
        expected_q = {expected_q, o};
      end else begin
        lim = (rule_count_q > RuleSlots) ? RuleSlots : int'(rule_count_q);
        for (int pass = 0; pass < lim; pass++) begin
          if (known[rq.goal]) break;
          for (int i = 0; i < lim; i++) begin
            if ((known & rule_cond[i]) == rule_cond[i] && !known[rule_concl[i]]) begin
              known[rule_concl[i]] = 1'b1;
              o = '{fcre_pkg::KIND_STEP, CntW'(i + 1), fcre_pkg::STAT_REACHED, known, 1'b0};
              expected_q = {expected_q, o};
              break;
            end
          end
        end
        o = '{fcre_pkg::KIND_STATUS, '0,
              known[rq.goal] ? fcre_pkg::STAT_REACHED : fcre_pkg::STAT_MISSED, known, 1'b1};
        expected_q = {expected_q, o};
      end
    end
  endtask

  // Sender: bursts of back-to-back requests separated by random gaps
  always @(posedge clk_i) begin : drive_proc
    logic go;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      go = start_i;
      if (start_i && !busy_o) begin
        derive_outcomes(cur_req);
        go = 1'b0;
      end
      if (!go) begin
        if (idle_left != 0) begin
          idle_left = idle_left - 1;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          mode_i              <= cur_req.mode;
          rule_slot_i         <= cur_req.slot;
          condition_mask_i    <= cur_req.cond;
          conclusion_symbol_i <= cur_req.concl;
          initial_facts_i     <= cur_req.facts;
          goal_symbol_i       <= cur_req.goal;
          go = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left = burst_left - 1;
          end
        end
      end
      start_i <= go;
    end
  end

  // Results cannot be held off: check each strobe against the oldest expectation
  always @(posedge clk_i) begin : check_proc
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d rule=%0d status=%0d facts=%h last=%0d",
                 $time, item_kind_o, fired_rule_o, status_o, final_facts_o, last_item_o);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (item_kind_o !== want.kind) begin
          $display("%0t: item_kind expected %0d actual %0d", $time, want.kind, item_kind_o);
          fail_count++;
        end
        if (fired_rule_o !== want.rule) begin
          $display("%0t: fired_rule expected %0d actual %0d", $time, want.rule, fired_rule_o);
          fail_count++;
        end
        if (status_o !== want.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, want.stat, status_o);
          fail_count++;
        end
        if (final_facts_o !== want.facts) begin
          $display("%0t: final_facts expected %h actual %h", $time, want.facts, final_facts_o);
          fail_count++;
        end
        if (last_item_o !== want.last) begin
          $display("%0t: last_item expected %0d actual %0d", $time, want.last, last_item_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [MaskW-1:0] rand_mask64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [MaskW-1:0] pool_mask(input int max_bits);
    logic [MaskW-1:0] m;
    int k;
    m = '0;
    k = $urandom_range(0, max_bits);
    repeat (k) m[sym_pool[$urandom_range(0, PoolSize - 1)]] = 1'b1;
    return m;
  endfunction

  // Unused fields of each request carry random values too
  task automatic add_load(input int slot, input logic [MaskW-1:0] cond,
                          input logic [SymW-1:0] concl);
    request_t rq;
    rq = '{fcre_pkg::MODE_LOAD, SlotW'(slot), cond, concl, rand_mask64(), SymW'($urandom)};
    request_q = {request_q, rq};
  endtask

  task automatic add_query(input logic [MaskW-1:0] facts, input logic [SymW-1:0] goal);
    request_t rq;
    rq = '{fcre_pkg::MODE_QUERY, SlotW'($urandom), rand_mask64(), SymW'($urandom), facts, goal};
    request_q = {request_q, rq};
  endtask

  task automatic add_pool_load(input int slot);
    int r;
    logic [MaskW-1:0] cond;
    logic [SymW-1:0] concl;
    r = $urandom_range(0, 9);
    if (r == 0) cond = rand_mask64();
    else if (r == 1) cond = '0;
    else cond = pool_mask(2);
    if ($urandom_range(0, 9) == 0) concl = SymW'($urandom);
    else concl = sym_pool[$urandom_range(0, PoolSize - 1)];
    add_load(slot, cond, concl);
  endtask

  // Wait until all requests are sent, all results are checked and the core is idle;
  // sample on the falling edge so every driver update has settled
  task automatic settle();
    @(negedge clk_i);
    while (request_q.size() != 0 || start_i || expected_q.size() != 0 || busy_o)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rule_count(input logic [CntW-1:0] value);
    settle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rule_count_q = value;
  endtask

  initial begin
    int issued;
    int phase;
    int sel;
    int val;
    int n;
    int nq;
    issued = 0;
    phase = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // No rules in use: goal already known, or missed at once
    add_query('1, 6'd63);
    add_query('0, 6'd0);
    add_query(64'h8000_0000_0000_0000, 6'd0);

    write_rule_count(6'd3);
    add_load(0, '0, 6'd5);
    add_load(1, 64'h20, 6'd63);
    add_load(2, ~64'h1, 6'd0);
    add_load(31, '1, 6'd63);
    add_query('0, 6'd63);                            // two-step chain
    add_query(~64'h1, 6'd0);                         // all-but-one condition
    add_query('0, 6'd7);                             // stall after chain, missed
    add_query(64'h20, 6'd63);                        // skip rule whose conclusion is known
    add_query(64'h8000_0000_0000_0020, 6'd0);        // nothing can fire

    // One pass only: the chain is cut short
    write_rule_count(6'd1);
    add_query('0, 6'd63);

    while (issued < RandItems) begin
      if (phase == 0) begin
        val = 63;
      end else if (phase == 1) begin
        val = 0;
      end else if (phase == 2) begin
        val = 32;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel == 0) val = 0;
        else if (sel == 1) val = 32;
        else if (sel == 2) val = $urandom_range(33, 63);
        else if (sel == 3) val = 1;
        else val = $urandom_range(2, 12);
      end
      phase++;
      write_rule_count(CntW'(val));
      n = (val > RuleSlots) ? RuleSlots : val;
      foreach (sym_pool[k]) sym_pool[k] = SymW'($urandom);

      // Every slot in use is written before any query of this phase
      for (int s = 0; s < n; s++) add_pool_load(s);
      repeat ($urandom_range(0, 3)) add_pool_load($urandom_range(0, RuleSlots - 1));
      issued += n;

      nq = $urandom_range(12, 24);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(0, 7) == 0) begin
          add_pool_load($urandom_range(0, RuleSlots - 1));
          issued++;
        end
        add_query(($urandom_range(0, 7) == 0) ? rand_mask64() : pool_mask(3),
                  ($urandom_range(0, 7) == 0) ? SymW'($urandom)
                                              : sym_pool[$urandom_range(0, PoolSize - 1)]);
        issued++;
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
